>>> sv/bytecode_vm_execute_unit_top_assert.svh
// Assertion macros shared by the execute unit modules.
`ifndef BYTECODE_VM_EXECUTE_UNIT_TOP_ASSERT_SVH
`define BYTECODE_VM_EXECUTE_UNIT_TOP_ASSERT_SVH

// Clocked check, off while in reset.
`define BVM_EU_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bvm_eu check failed");

// Same, with a message of its own.
`define BVM_EU_CHK_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`endif

>>> sv/bvm_eu_pkg.sv
// Types, constants and helpers of the bytecode VM execute unit.
`default_nettype none

package bvm_eu_pkg;

  localparam int NUM_REGS        = 256;
  localparam int REG_AW          = 8;
  localparam int NUM_THREADS     = 64;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [REG_AW-1:0] SEED_REG    = 8'h3c;
  localparam logic [REG_AW-1:0] MAGIC_REG   = 8'h54;
  localparam logic [15:0]       MAGIC_VAL   = 16'h0081;
  localparam logic [15:0]       PC_INACTIVE = 16'hffff;

  localparam int CMP_REG_BIT  = 7;
  localparam int CMP_WORD_BIT = 6;

  typedef enum logic [5:0] {
    OP_MOVL  = 6'h00,
    OP_MOVR  = 6'h01,
    OP_ADDR  = 6'h02,
    OP_ADDL  = 6'h03,
    OP_CALL  = 6'h04,
    OP_RET   = 6'h05,
    OP_PAUSE = 6'h06,
    OP_JMP   = 6'h07,
    OP_SPAWN = 6'h08,
    OP_JNZ   = 6'h09,
    OP_CJMP  = 6'h0a,
    OP_KILL  = 6'h11,
    OP_SUBR  = 6'h13,
    OP_ANDL  = 6'h14,
    OP_ORL   = 6'h15,
    OP_SHLL  = 6'h16,
    OP_SHRL  = 6'h17
  } opcode_t;

  typedef enum logic [2:0] {
    CMP_EQ = 3'd0,
    CMP_NE = 3'd1,
    CMP_GT = 3'd2,
    CMP_GE = 3'd3,
    CMP_LT = 3'd4,
    CMP_LE = 3'd5
  } cmp_t;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_OVERFLOW  = 2'd1,
    FAULT_UNDERFLOW = 2'd2
  } fault_t;

  typedef struct packed {
    logic [5:0]  thr_id;
    logic [5:0]  opcode;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_c;
    logic [7:0]  byte_d;
    logic [15:0] word_operand;
    logic [15:0] fall_through_pc;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        end_slice;
    logic [1:0]  stack_fault;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr0;
    logic [REG_AW-1:0] addr1;
  } rf_rd_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [15:0]       data;
  } rf_wr_t;

  function automatic logic [15:0] reg_reset_val(input logic [REG_AW-1:0] idx);
    return (idx == MAGIC_REG) ? MAGIC_VAL : 16'h0000;
  endfunction

endpackage

`default_nettype wire

>>> sv/bvm_eu_stream_if.sv
// Valid/ready channel carrying one payload beat.
`default_nettype none

interface bvm_eu_stream_if #(
  parameter type payload_t = logic [15:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/bvm_eu_regfile.sv
// 256 x 16 register file: two registered read ports, write forwarding, reset by valid bits.
`default_nettype none
`include "bytecode_vm_execute_unit_top_assert.svh"

module bvm_eu_regfile (
  input  logic                clk,
  input  logic                rst,
  input  bvm_eu_pkg::rf_rd_t  rd,
  input  bvm_eu_pkg::rf_wr_t  wr,
  output logic [15:0]         rd0_data,
  output logic [15:0]         rd1_data
);
  import bvm_eu_pkg::*;

  logic [15:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid;

  logic [15:0] rd0_mem;
  logic [15:0] rd1_mem;
  logic        rd0_ovr;
  logic        rd1_ovr;
  logic [15:0] rd0_alt;
  logic [15:0] rd1_alt;
  logic        hit0;
  logic        hit1;

  assign hit0 = wr.en && (wr.addr == rd.addr0);
  assign hit1 = wr.en && (wr.addr == rd.addr1);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd0_mem <= mem[rd.addr0];
      rd1_mem <= mem[rd.addr1];
      rd0_ovr <= hit0 || !valid[rd.addr0];
      rd1_ovr <= hit1 || !valid[rd.addr1];
      rd0_alt <= hit0 ? wr.data : reg_reset_val(rd.addr0);
      rd1_alt <= hit1 ? wr.data : reg_reset_val(rd.addr1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  assign rd0_data = rd0_ovr ? rd0_alt : rd0_mem;
  assign rd1_data = rd1_ovr ? rd1_alt : rd1_mem;

  `BVM_EU_CHK(a_wr_sets_valid, wr.en |=> valid[$past(wr.addr)])
  `BVM_EU_CHK(a_fwd_port0, (hit0 && rd.en) |=> (rd0_data == $past(wr.data)))
  `BVM_EU_CHK_MSG(a_rd1_hold, !rd.en |=> $stable(rd1_data), "read data moved without a read")

endmodule

`default_nettype wire

>>> sv/bytecode_vm_execute_unit_top.sv
// Top level of the bytecode VM execute unit.
//
// Channels: instr (sink) takes one fetched instruction per beat, result
// (source) gives one beat per instruction with the thread's next pc, the
// end-of-slice flag and the stack fault code. cfg (sink, always ready)
// writes the random seed into register 0x3c.
// A taken instruction beat is registered into the execute stage, its result
// into the result register. Throughput: one instruction per cycle unless the
// result stalls. Register file reads at the input edge are registered, and
// write-back is done by the execute stage, forwarded to a read at that edge.
// The return stack keeps its top entry in a register, refreshed every cycle.
// Reset (rst, synchronous): pipeline empty, stack empty, register file back
// to zero with register 0x54 = 0x81 (through valid bits, no clearing pass).
// Stall: while result is not taken the result register holds; one more
// instruction can be taken into the execute stage, then instr.ready drops.
`default_nettype none
`include "bytecode_vm_execute_unit_top_assert.svh"

module bytecode_vm_execute_unit_top #(
  parameter int STACK_DEPTH = bvm_eu_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  bvm_eu_stream_if.sink   instr,
  bvm_eu_stream_if.source result,
  bvm_eu_stream_if.sink   cfg
);
  import bvm_eu_pkg::*;

  localparam int SpW   = $clog2(STACK_DEPTH + 1);
  localparam int StkAw = $clog2(STACK_DEPTH);

  logic     in_fire;
  logic     cfg_fire;
  logic     s1_valid;
  instr_t   s1;
  logic     s1_fire;
  logic     out_valid;
  result_t  out_q;

  rf_rd_t      rd;
  rf_wr_t      wr;
  logic [15:0] rd0_data;
  logic [15:0] rd1_data;

  logic [15:0]     stk_mem [STACK_DEPTH];
  logic [15:0]     stk_top;
  logic [SpW-1:0]  sp;
  logic [SpW-1:0]  sp_next;
  logic [StkAw-1:0] top_idx;
  logic            push_fire;
  logic            pop_fire;

  logic [15:0] pc_n;
  logic        end_n;
  fault_t      fault_n;
  logic        wr_reg;
  logic [15:0] wr_val;
  logic        push;
  logic        pop;
  logic [15:0] dec_val;
  logic signed [15:0] cmp_x;
  logic signed [15:0] cmp_y;
  logic        jump;

  assign in_fire  = instr.valid && instr.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign s1_fire  = s1_valid && (!out_valid || result.ready);

  assign instr.ready  = !s1_valid || s1_fire;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_q;

  always_comb begin
    rd.en    = in_fire;
    rd.addr0 = ((instr.data.opcode == OP_CJMP) && instr.data.byte_a[CMP_REG_BIT])
               ? instr.data.byte_c : instr.data.byte_a;
    rd.addr1 = instr.data.byte_b;
  end

  bvm_eu_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .wr       (wr),
    .rd0_data (rd0_data),
    .rd1_data (rd1_data)
  );

  // Compare operands: rd1 is reg[b], rd0 is reg[c] in register mode.
  always_comb begin
    cmp_x = signed'(rd1_data);
    if (s1.byte_a[CMP_REG_BIT]) begin
      cmp_y = signed'(rd0_data);
    end else if (s1.byte_a[CMP_WORD_BIT]) begin
      cmp_y = signed'({s1.byte_c, s1.byte_d});
    end else begin
      cmp_y = signed'({8'h00, s1.byte_c});
    end
    case (s1.byte_a[2:0])
      CMP_EQ:  jump = (cmp_x == cmp_y);
      CMP_NE:  jump = (cmp_x != cmp_y);
      CMP_GT:  jump = (cmp_x > cmp_y);
      CMP_GE:  jump = (cmp_x >= cmp_y);
      CMP_LT:  jump = (cmp_x < cmp_y);
      CMP_LE:  jump = (cmp_x <= cmp_y);
      default: jump = 1'b0;
    endcase
  end

  assign dec_val = rd0_data - 16'd1;

  always_comb begin
    pc_n    = s1.fall_through_pc;
    end_n   = 1'b0;
    fault_n = FAULT_NONE;
    wr_reg  = 1'b0;
    wr_val  = 16'h0000;
    push    = 1'b0;
    pop     = 1'b0;
    case (s1.opcode)
      OP_MOVL: begin
        wr_reg = 1'b1;
        wr_val = s1.word_operand;
      end
      OP_MOVR: begin
        wr_reg = 1'b1;
        wr_val = rd1_data;
      end
      OP_ADDR: begin
        wr_reg = 1'b1;
        wr_val = rd0_data + rd1_data;
      end
      OP_ADDL: begin
        wr_reg = 1'b1;
        wr_val = rd0_data + s1.word_operand;
      end
      OP_CALL: begin
        if (sp == SpW'(STACK_DEPTH)) begin
          fault_n = FAULT_OVERFLOW;
        end else begin
          push = 1'b1;
          pc_n = s1.word_operand;
        end
      end
      OP_RET: begin
        if (sp == '0) begin
          fault_n = FAULT_UNDERFLOW;
        end else begin
          pop  = 1'b1;
          pc_n = stk_top;
        end
      end
      OP_PAUSE: begin
        end_n = 1'b1;
      end
      OP_JMP: begin
        pc_n = s1.word_operand;
      end
      OP_SPAWN: begin
        if (({1'b0, s1.byte_a} < 9'(NUM_THREADS)) &&
            (s1.byte_a == {2'b00, s1.thr_id})) begin
          pc_n = s1.word_operand;
        end
      end
      OP_JNZ: begin
        wr_reg = 1'b1;
        wr_val = dec_val;
        if (dec_val != 16'h0000) begin
          pc_n = s1.word_operand;
        end
      end
      OP_CJMP: begin
        if (jump) begin
          pc_n = s1.word_operand;
        end
      end
      OP_KILL: begin
        pc_n  = PC_INACTIVE;
        end_n = 1'b1;
      end
      OP_SUBR: begin
        wr_reg = 1'b1;
        wr_val = rd0_data - rd1_data;
      end
      OP_ANDL: begin
        wr_reg = 1'b1;
        wr_val = rd0_data & s1.word_operand;
      end
      OP_ORL: begin
        wr_reg = 1'b1;
        wr_val = rd0_data | s1.word_operand;
      end
      OP_SHLL: begin
        wr_reg = 1'b1;
        wr_val = (s1.word_operand[15:4] != '0) ? 16'h0000
                 : (rd0_data << s1.word_operand[3:0]);
      end
      OP_SHRL: begin
        wr_reg = 1'b1;
        wr_val = (s1.word_operand[15:4] != '0) ? 16'h0000
                 : (rd0_data >> s1.word_operand[3:0]);
      end
      default: begin
        pc_n = s1.fall_through_pc;
      end
    endcase
  end

  always_comb begin
    wr.en   = cfg_fire || (s1_fire && wr_reg);
    wr.addr = cfg_fire ? SEED_REG : s1.byte_a;
    wr.data = cfg_fire ? cfg.data : wr_val;
  end

  // Return stack
  assign push_fire = s1_fire && push;
  assign pop_fire  = s1_fire && pop;

  always_comb begin
    sp_next = sp;
    if (push_fire) begin
      sp_next = sp + 1'b1;
    end else if (pop_fire) begin
      sp_next = sp - 1'b1;
    end
  end

  always_comb begin
    if (sp_next == '0) begin
      top_idx = '0;
    end else begin
      top_idx = StkAw'(sp_next - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      stk_mem[sp[StkAw-1:0]] <= s1.fall_through_pc;
      stk_top <= s1.fall_through_pc;
    end else begin
      stk_top <= stk_mem[top_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      sp <= sp_next;
    end
  end

  // Execute stage and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= instr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_q.next_pc     <= pc_n;
      out_q.end_slice   <= end_n;
      out_q.stack_fault <= fault_n;
    end
  end

  `BVM_EU_CHK(a_sp_range, sp <= SpW'(STACK_DEPTH))
  `BVM_EU_CHK(a_push_sp, push_fire |=> (sp == $past(sp) + 1'b1))
  `BVM_EU_CHK_MSG(a_fault_keeps_sp, (s1_fire && (fault_n != FAULT_NONE)) |=> $stable(sp),
    "stack pointer moved on a stack fault")

endmodule

`default_nettype wire
